FILE: hdl/keyed_semaphore_table_core_assert.svh
// Assertion macros for the keyed semaphore table core.
`ifndef KEYED_SEMAPHORE_TABLE_CORE_ASSERT_SVH
`define KEYED_SEMAPHORE_TABLE_CORE_ASSERT_SVH
`ifndef SYNTH
`define KST_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define KST_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define KST_ASSERT_IMP(label, clk, rst_n, a, c)
`define KST_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

FILE: hdl/kst_pkg.sv
// Shared types and codes for the keyed semaphore table core.
package kst_pkg;

    localparam logic [2:0] REQ_CREATE = 3'd0;
    localparam logic [2:0] REQ_GET    = 3'd1;
    localparam logic [2:0] REQ_SIGNAL = 3'd2;
    localparam logic [2:0] REQ_WAIT   = 3'd3;
    localparam logic [2:0] REQ_CLOSE  = 3'd4;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_DESC    = 3'd1;
    localparam logic [2:0] ST_DUP_KEY     = 3'd2;
    localparam logic [2:0] ST_TABLE_FULL  = 3'd3;
    localparam logic [2:0] ST_PROC_FULL   = 3'd4;
    localparam logic [2:0] ST_KEY_MISSING = 3'd5;
    localparam logic [2:0] ST_WOULD_BLOCK = 3'd6;
    localparam logic [2:0] ST_SATURATED   = 3'd7;

    localparam logic [7:0] REF_MAX = 8'hFF;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic scan_clr;
        logic scan_step;
        logic exec;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_last;
    } stat_t;

endpackage

FILE: hdl/kst_ctrl.sv
// Controller state machine for the keyed semaphore table core.
module kst_ctrl
    import kst_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    output cmd_t  cmd,
    input  stat_t stat
);

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    cmd.scan_clr = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

FILE: hdl/kst_datapath.sv
// Tables, slot scan and request execution for the keyed semaphore table core.
module kst_datapath
    import kst_pkg::*;
#(
    parameter int NUM_SEMS      = 16,
    parameter int DESC_PER_PROC = 8,
    parameter int NUM_PROCS     = 16,
    parameter int COUNT_BITS    = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  logic [2:0]  req_type,
    input  logic [3:0]  proc_id,
    input  logic [15:0] sem_key_in,
    input  logic [15:0] init_count,
    input  logic [2:0]  desc_in,
    output logic [2:0]  status,
    output logic [2:0]  desc_out,
    output logic        wake_waiters
);

    localparam int SB = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
    localparam int DB = (DESC_PER_PROC > 1) ? $clog2(DESC_PER_PROC) : 1;
    localparam int TOT = NUM_PROCS * DESC_PER_PROC;
    localparam int TB = (TOT > 1) ? $clog2(TOT) : 1;
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

    logic [COUNT_BITS-1:0] count_reg [NUM_SEMS];
    logic [15:0]           key_reg   [NUM_SEMS];
    logic [7:0]            ref_reg   [NUM_SEMS];
    logic [TOT-1:0]        used_reg;

    logic [2:0]  req_reg;
    logic [3:0]  proc_reg;
    logic [15:0] key_in_reg;
    logic [15:0] init_reg;
    logic [2:0]  din_reg;

    logic [SB-1:0] scan_reg;
    logic          hit_reg, free_reg;
    logic [SB-1:0] hit_slot_reg, free_slot_reg;

    logic [2:0] status_reg, dout_reg;
    logic       wake_reg;

    // latch request
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg    <= req_type;
            proc_reg   <= proc_id;
            key_in_reg <= sem_key_in;
            init_reg   <= init_count;
            din_reg    <= desc_in;
        end
    end

    // one slot per cycle: first live key match and first free slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= '0;
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end
        else if (cmd.scan_clr)
        begin
            scan_reg <= '0;
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            scan_reg <= scan_reg + 1'b1;
            if (!hit_reg && ref_reg[scan_reg] != 8'd0 && key_reg[scan_reg] == key_in_reg)
            begin
                hit_reg <= 1'b1;
                hit_slot_reg <= scan_reg;
            end
            if (!free_reg && ref_reg[scan_reg] == 8'd0)
            begin
                free_reg <= 1'b1;
                free_slot_reg <= scan_reg;
            end
        end
    end

    assign stat.scan_last = (scan_reg == SB'(NUM_SEMS - 1));

    // descriptor slot memory
    logic          ds_we;
    logic [TB-1:0] ds_waddr, ds_raddr;
    logic [SB-1:0] ds_wdata, ds_rdata;

    kst_ram #(.WIDTH(SB), .DEPTH(TOT)) u_desc_slot (
        .clk   (clk),
        .we    (ds_we),
        .waddr (ds_waddr),
        .wdata (ds_wdata),
        .raddr (ds_raddr),
        .rdata (ds_rdata)
    );

    // descriptor view of this process
    logic              proc_ok, din_ok, d_used;
    logic              have_free;
    logic [DB-1:0]     free_d;
    logic [TB-1:0]     base, idx_in, idx_free;

    assign proc_ok = ({28'd0, proc_reg} < NUM_PROCS);
    assign base    = TB'(proc_reg * DESC_PER_PROC);
    assign din_ok  = ({29'd0, din_reg} < DESC_PER_PROC);
    assign idx_in  = base + TB'(din_reg);
    assign ds_raddr = idx_in;
    assign d_used  = used_reg[idx_in];

    always_comb
    begin
        have_free = 1'b0;
        free_d = '0;
        for (int d = DESC_PER_PROC - 1; d >= 0; d--)
        begin
            if (!used_reg[base + TB'(d)])
            begin
                have_free = 1'b1;
                free_d = DB'(d);
            end
        end
    end
    assign idx_free = base + TB'(free_d);

    // decide the request
    logic [2:0] st;
    logic       wk, alloc, do_sig, do_wait, do_close, do_get, do_create;
    logic [SB-1:0] s;

    assign s = ds_rdata;

    always_comb
    begin
        st = ST_BAD_DESC;
        wk = 1'b0;
        alloc = 1'b0;
        do_sig = 1'b0;
        do_wait = 1'b0;
        do_close = 1'b0;
        do_get = 1'b0;
        do_create = 1'b0;
        if (proc_ok)
        begin
            if (req_reg == REQ_CREATE || req_reg == REQ_GET)
            begin
                if (!have_free)
                    st = ST_PROC_FULL;
                else if (req_reg == REQ_CREATE)
                begin
                    if (hit_reg)
                        st = ST_DUP_KEY;
                    else if (!free_reg)
                        st = ST_TABLE_FULL;
                    else
                    begin
                        st = ST_OK;
                        alloc = 1'b1;
                        do_create = 1'b1;
                    end
                end
                else
                begin
                    if (!hit_reg)
                        st = ST_KEY_MISSING;
                    else if (ref_reg[hit_slot_reg] == REF_MAX)
                        st = ST_TABLE_FULL;
                    else
                    begin
                        st = ST_OK;
                        alloc = 1'b1;
                        do_get = 1'b1;
                    end
                end
            end
            else if ((req_reg == REQ_SIGNAL || req_reg == REQ_WAIT
                      || req_reg == REQ_CLOSE) && din_ok && d_used)
            begin
                st = ST_OK;
                if (req_reg == REQ_SIGNAL)
                begin
                    wk = 1'b1;
                    if (count_reg[s] == CMAX)
                        st = ST_SATURATED;
                    else
                        do_sig = 1'b1;
                end
                else if (req_reg == REQ_WAIT)
                begin
                    if (count_reg[s] == '0)
                        st = ST_WOULD_BLOCK;
                    else
                        do_wait = 1'b1;
                end
                else
                    do_close = 1'b1;
            end
        end
    end

    assign ds_we    = cmd.exec && alloc;
    assign ds_waddr = idx_free;
    assign ds_wdata = do_create ? free_slot_reg : hit_slot_reg;

    // initial count saturates to the count range
    logic [COUNT_BITS-1:0] init_sat;
    always_comb
    begin
        if (COUNT_BITS < 16 && (init_reg >> COUNT_BITS) != 16'd0)
            init_sat = CMAX;
        else
            init_sat = COUNT_BITS'(init_reg);
    end

    // table updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            for (int i = 0; i < NUM_SEMS; i++)
            begin
                count_reg[i] <= '0;
                key_reg[i]   <= '0;
                ref_reg[i]   <= '0;
            end
        end
        else if (cmd.exec)
        begin
            if (alloc)
                used_reg[idx_free] <= 1'b1;
            if (do_close)
            begin
                used_reg[idx_in] <= 1'b0;
                if (ref_reg[s] != 8'd0)
                    ref_reg[s] <= ref_reg[s] - 8'd1;
            end
            if (do_create)
            begin
                count_reg[free_slot_reg] <= init_sat;
                key_reg[free_slot_reg]   <= key_in_reg;
                ref_reg[free_slot_reg]   <= 8'd1;
            end
            if (do_get)
                ref_reg[hit_slot_reg] <= ref_reg[hit_slot_reg] + 8'd1;
            if (do_sig)
                count_reg[s] <= count_reg[s] + 1'b1;
            if (do_wait)
                count_reg[s] <= count_reg[s] - 1'b1;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            status_reg <= st;
            dout_reg   <= alloc ? 3'(free_d) : 3'd0;
            wake_reg   <= wk;
        end
    end

    assign status       = status_reg;
    assign desc_out     = dout_reg;
    assign wake_waiters = wake_reg;

endmodule

FILE: hdl/kst_ram.sv
// Generic single-write, registered-read RAM.
module kst_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 128
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/keyed_semaphore_table_core.sv
// Each transaction: accept, a scan of all NUM_SEMS slots (one slot per cycle),
// execute, then the result is held until taken.
// A new transaction is accepted only once the previous result is taken.
// Reset (rst_n, async, low) frees all slots and descriptors at once; no sweep.
// The descriptor slot RAM is not cleared; only used descriptors are read.
module keyed_semaphore_table_core
    import kst_pkg::*;
#(
    parameter int NUM_SEMS      = 16,
    parameter int DESC_PER_PROC = 8,
    parameter int NUM_PROCS     = 16,
    parameter int COUNT_BITS    = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  req_type,
    input  logic [3:0]  proc_id,
    input  logic [15:0] sem_key_in,
    input  logic [15:0] init_count,
    input  logic [2:0]  desc_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [2:0]  desc_out,
    output logic        wake_waiters
);

`include "keyed_semaphore_table_core_assert.svh"

    cmd_t  cmd;
    stat_t stat;

    kst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    kst_datapath #(
        .NUM_SEMS      (NUM_SEMS),
        .DESC_PER_PROC (DESC_PER_PROC),
        .NUM_PROCS     (NUM_PROCS),
        .COUNT_BITS    (COUNT_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .req_type     (req_type),
        .proc_id      (proc_id),
        .sem_key_in   (sem_key_in),
        .init_count   (init_count),
        .desc_in      (desc_in),
        .status       (status),
        .desc_out     (desc_out),
        .wake_waiters (wake_waiters)
    );

    // no new transaction while a result waits
    `KST_ASSERT_IMP(a_no_overlap, clk, rst_n, out_valid, !in_ready)
    // execute is always followed by a valid result
    `KST_ASSERT_NXT(a_exec_result, clk, rst_n, cmd.exec, out_valid)
    // wake only with signal outcomes
    `KST_ASSERT_IMP(a_wake_status, clk, rst_n, out_valid && wake_waiters,
        status == ST_OK || status == ST_SATURATED)
    // a descriptor is reported only on success
    `KST_ASSERT_IMP(a_desc_ok, clk, rst_n, out_valid && desc_out != 3'd0,
        status == ST_OK)

endmodule
